FILE: hdl/bank_switch_mapper_with_cycle_irq_macros.svh
// Assertion macros shared by the mapper RTL files.
`ifndef BANK_SWITCH_MAPPER_WITH_CYCLE_IRQ_MACROS_SVH
`define BANK_SWITCH_MAPPER_WITH_CYCLE_IRQ_MACROS_SVH

// Clocked check, off while reset is held.
`define BSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define BSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: hdl/bsm_pkg.sv
// Types and constants of the bank switch mapper.
`default_nettype none

package bsm_pkg;

  localparam int PAGE_SLOTS  = 8;
  localparam int PAGE_IDX_W  = $clog2(PAGE_SLOTS);
  localparam int CHR_PAGE_W  = 11;
  localparam int PRG_COUNT_W = 9;
  localparam int PRG_BANK_W  = 8;
  localparam int IRQ_CNT_W   = 16;
  localparam int MIRROR_W    = 3;
  localparam int OFFSET_W    = 22;
  localparam int CFG_DATA_W  = 11;

  // Shared remainder unit: dividend up to 2*255, divisor up to an 11-bit count.
  localparam int MOD_DVD_W = 9;
  localparam int MOD_DVS_W = 11;
  localparam int MOD_CNT_W = $clog2(MOD_DVD_W + 1);

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_PRG   = 2'd2;
  localparam logic [1:0] FUNC_CHR   = 2'd3;

  // Write decode: address bits 15:11.
  localparam logic [4:0] DEC_CHR0     = 5'h11;
  localparam logic [4:0] DEC_CHR1     = 5'h13;
  localparam logic [4:0] DEC_CHR2     = 5'h15;
  localparam logic [4:0] DEC_CHR3     = 5'h17;
  localparam logic [4:0] DEC_IRQ_LOAD = 5'h19;
  localparam logic [4:0] DEC_IRQ_CTRL = 5'h1B;
  localparam logic [4:0] DEC_MIRROR   = 5'h1D;
  localparam logic [4:0] DEC_PRG      = 5'h1F;

  localparam logic CFG_PRG_BANKS = 1'b0;
  localparam logic CFG_CHR_PAGES = 1'b1;

  localparam logic [MIRROR_W-1:0] MIRROR_HEADER = 3'd4;
  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 9'd2;
  localparam logic [CHR_PAGE_W-1:0] CHR_COUNT_RESET = 11'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  data;
    logic [15:0] cycles;
  } bsm_in_t;

  typedef struct packed {
    logic                irq;
    logic [MIRROR_W-1:0] mirroring;
    logic [OFFSET_W-1:0] rom_offset;
  } bsm_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_EXEC
  } bsm_state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic commit;
  } bsm_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_done;
  } bsm_sts_t;

endpackage

`default_nettype wire

FILE: hdl/bsm_mod.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none

`include "bank_switch_mapper_with_cycle_irq_macros.svh"

module bsm_mod
  import bsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MOD_DVD_W-1:0] dividend,
  input  logic [MOD_DVS_W-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic [MOD_DVS_W-1:0] remainder
);

  logic [MOD_CNT_W-1:0] cnt;
  logic [MOD_DVD_W-1:0] shift;
  logic [MOD_DVS_W-1:0] dvs;
  logic [MOD_DVS_W-1:0] rem;
  logic [MOD_DVS_W-1:0] rem_next;
  logic [MOD_DVS_W:0]   trial;

  always_comb begin
    trial = {rem, shift[MOD_DVD_W-1]};
    if (trial >= {1'b0, dvs}) begin
      trial = trial - {1'b0, dvs};
    end
    rem_next = trial[MOD_DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MOD_CNT_W'(MOD_DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MOD_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shift <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= rem_next;
      shift <= {shift[MOD_DVD_W-2:0], 1'b0};
    end
  end

  assign remainder = rem;

  `BSM_ASSERT(a_mod_done_pulse, done |=> !done, "remainder done held longer than one cycle")
  `BSM_ASSERT_ALWAYS(a_mod_cnt_live, busy |-> cnt != '0, "remainder unit busy with no steps left")

endmodule

`default_nettype wire

FILE: hdl/bsm_dpath.sv
// Mapper datapath: configuration, bank and IRQ state, address translation.
`default_nettype none

`include "bank_switch_mapper_with_cycle_irq_macros.svh"

module bsm_dpath
  import bsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  bsm_in_t               in_item,
  output bsm_out_t              out_item,
  input  bsm_cmd_t              cmd,
  output bsm_sts_t              sts
);

  logic [PRG_COUNT_W-1:0] prg_bank_count;
  logic [CHR_PAGE_W-1:0]  chr_page_count;
  bsm_in_t                item;

  logic [CHR_PAGE_W-1:0] pattern_page      [PAGE_SLOTS];
  logic [CHR_PAGE_W-1:0] pattern_page_next [PAGE_SLOTS];
  logic [PRG_BANK_W-1:0] program_bank, program_bank_next;
  logic [MIRROR_W-1:0]   mirror_mode, mirror_mode_next;
  logic [IRQ_CNT_W-1:0]  irq_count, irq_count_next;
  logic                  low_byte_next, low_byte_next_next;
  logic                  count_enable, count_enable_next;
  logic                  irq_flag, irq_flag_next;

  logic [4:0]            dec;
  logic [1:0]            slot;
  logic                  prg_write;
  logic                  mod_busy, mod_done;
  logic [MOD_DVD_W-1:0]  mod_dividend;
  logic [MOD_DVS_W-1:0]  mod_divisor;
  logic [MOD_DVS_W-1:0]  mod_rem;
  logic [CHR_PAGE_W:0]   rem_inc;
  logic [CHR_PAGE_W-1:0] page_hi;
  logic [PRG_BANK_W-1:0] last_bank;
  logic [PRG_BANK_W-1:0] prg_sel;
  logic [CHR_PAGE_W-1:0] chr_sel;
  logic [OFFSET_W-1:0]   offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
      chr_page_count <= CHR_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PRG_BANKS: prg_bank_count <= cfg_data[PRG_COUNT_W-1:0];
        CFG_CHR_PAGES: chr_page_count <= cfg_data[CHR_PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
  end

  assign dec       = item.address[15:11];
  assign slot      = item.address[13:12];
  assign prg_write = (dec == DEC_PRG);

  assign sts.need_div = (item.func == FUNC_WRITE) &&
                        (dec == DEC_CHR0 || dec == DEC_CHR1 || dec == DEC_CHR2 ||
                         dec == DEC_CHR3 || dec == DEC_PRG);
  assign sts.div_busy = mod_busy;
  assign sts.div_done = mod_done;

  // Pattern writes reduce 2*data, program writes reduce data.
  assign mod_dividend = prg_write ? {1'b0, item.data} : {item.data, 1'b0};
  assign mod_divisor  = prg_write ? {2'b00, prg_bank_count} : chr_page_count;

  bsm_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .busy      (mod_busy),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Odd page of the pair: one past the even page, wrapped at the page count.
  assign rem_inc = {1'b0, mod_rem} + 1'b1;
  assign page_hi = (rem_inc == {1'b0, chr_page_count}) ? '0 : rem_inc[CHR_PAGE_W-1:0];

  assign last_bank = (prg_bank_count == '0) ? '0 :
                     PRG_BANK_W'(prg_bank_count - 1'b1);

  always_comb begin
    pattern_page_next  = pattern_page;
    program_bank_next  = program_bank;
    mirror_mode_next   = mirror_mode;
    irq_count_next     = irq_count;
    low_byte_next_next = low_byte_next;
    count_enable_next  = count_enable;
    irq_flag_next      = irq_flag;
    prg_sel            = item.address[14] ? last_bank : program_bank;
    chr_sel            = pattern_page[item.address[12:10]];
    offset             = '0;
    unique case (item.func)
      FUNC_WRITE: begin
        unique case (dec)
          DEC_CHR0, DEC_CHR1, DEC_CHR2, DEC_CHR3: begin
            if (chr_page_count != '0) begin
              pattern_page_next[{slot, 1'b0}] = mod_rem;
              pattern_page_next[{slot, 1'b1}] = page_hi;
            end
          end
          DEC_IRQ_LOAD: begin
            if (!low_byte_next) begin
              irq_count_next[15:8] = item.data;
            end else begin
              irq_count_next[7:0] = item.data;
            end
            low_byte_next_next = !low_byte_next;
          end
          DEC_IRQ_CTRL: begin
            count_enable_next  = item.data[4];
            low_byte_next_next = 1'b0;
            irq_flag_next      = 1'b0;
          end
          DEC_MIRROR: mirror_mode_next = {1'b0, item.data[1:0]};
          DEC_PRG: begin
            program_bank_next = (prg_bank_count == '0) ? '0 : mod_rem[PRG_BANK_W-1:0];
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (count_enable) begin
          irq_count_next = irq_count - item.cycles;
          if (item.cycles > irq_count) begin
            irq_flag_next     = 1'b1;
            count_enable_next = 1'b0;
          end
        end
      end
      FUNC_PRG: offset = {prg_sel, item.address[13:0]};
      FUNC_CHR: offset = {1'b0, chr_sel, item.address[9:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        pattern_page[i] <= CHR_PAGE_W'(i);
      end
      program_bank  <= '0;
      mirror_mode   <= MIRROR_HEADER;
      irq_count     <= '0;
      low_byte_next <= 1'b0;
      count_enable  <= 1'b0;
      irq_flag      <= 1'b0;
    end else if (cmd.commit) begin
      pattern_page  <= pattern_page_next;
      program_bank  <= program_bank_next;
      mirror_mode   <= mirror_mode_next;
      irq_count     <= irq_count_next;
      low_byte_next <= low_byte_next_next;
      count_enable  <= count_enable_next;
      irq_flag      <= irq_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.irq        <= irq_flag_next;
      out_item.mirroring  <= mirror_mode_next;
      out_item.rom_offset <= offset;
    end
  end

  `BSM_ASSERT(a_dp_irq_from_tick, $rose(irq_flag) |-> $past(cmd.commit && item.func == FUNC_TICK),
    "IRQ raised by something other than a tick")

endmodule

`default_nettype wire

FILE: hdl/bsm_ctrl.sv
// Mapper controller: item sequencing and output register handshake.
`default_nettype none

`include "bank_switch_mapper_with_cycle_irq_macros.svh"

module bsm_ctrl
  import bsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output bsm_cmd_t cmd,
  input  bsm_sts_t sts
);

  bsm_state_t state, state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_LOAD;
      S_LOAD: state_next = sts.need_div ? S_DIV : S_EXEC;
      S_DIV:  if (sts.div_done) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != S_IDLE);
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.div_start = (state == S_LOAD) && sts.need_div;
    cmd.commit    = (state == S_EXEC) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result until the downstream transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `BSM_ASSERT(a_ctrl_div_alive, state == S_DIV |-> sts.div_busy || sts.div_done,
    "waiting on a remainder unit that is not running")
  `BSM_ASSERT(a_ctrl_out_from_exec, $rose(out_valid) |-> $past(state == S_EXEC),
    "result valid raised outside the execute step")

endmodule

`default_nettype wire

FILE: hdl/bank_switch_mapper_with_cycle_irq.sv
// Top level of the bank switch mapper with cycle-counting IRQ.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+----------------------------------
//   in       | in_valid / in_stall      | in_item: func, address, data, cycles
//   out      | out_valid / out_stall    | out_item: irq, mirroring, rom_offset
//   cfg      | cfg_write                | cfg_index, cfg_data
//
// One item at a time: ticks, translates and most writes pass load and execute
// to the result; pattern and program bank writes add a divide step, where the
// shared remainder unit takes one dividend bit per cycle over 9 bits.
// A waiting result does not block the next transfer in; only a full output
// register under out_stall holds an item in its final step.
// Synchronous reset restores the power-up banks, mirroring and counts at once.
`default_nettype none

module bank_switch_mapper_with_cycle_irq
  import bsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bsm_in_t               in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bsm_out_t              out_item
);

  bsm_cmd_t cmd;
  bsm_sts_t sts;

  bsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bsm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
